// ===== rtl/mppt_pkg.sv =====
// Shared types and constants of the multi-pad peak trigger unit.
// Used by the stream interfaces, the pad engine, the top level and the checker.
package mppt_pkg;

    localparam int PAD_W      = 3;
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int SCAN_W     = 16;
    localparam int MASK_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd100;
    localparam logic [SCAN_W-1:0]   SCAN_LEN_RESET  = 16'd3;
    localparam logic [MASK_W-1:0]   MASK_LEN_RESET  = 16'd30;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_MASK    = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SCAN_LEN  = 2'd1,
        REG_MASK_LEN  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_phase              phase;
        logic [SAMPLE_W-1:0] peak;
        logic [TIME_W-1:0]   start;
    } t_pad_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [SCAN_W-1:0]   scan_len;
        logic [MASK_W-1:0]   mask_len;
    } t_cfg;

endpackage

// ===== rtl/mppt_stream_if.sv =====
// Valid/ready stream interfaces for the sample input and the hit output.
// Field widths come from mppt_pkg.
interface mppt_sample_if import mppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PAD_W-1:0]    pad_index;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output pad_index, output sample, output now_ms,
                    input ready);
    modport sink (input valid, input pad_index, input sample, input now_ms,
                  output ready);
endinterface

interface mppt_hit_if import mppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PAD_W-1:0]    hit_pad;
    logic [SAMPLE_W-1:0] peak_value;

    modport source (output valid, output hit_pad, output peak_value, input ready);
    modport sink (input valid, input hit_pad, input peak_value, output ready);
endinterface

// ===== rtl/multi_pad_peak_trigger_unit.sv =====
// Top level of the multi-pad peak trigger unit: input register, per-pad state,
// result register and APB register file. Uses mppt_pkg, the stream interfaces
// and mppt_pad_engine.
//
// The unit takes one sample transfer per clock cycle; only a hit that waits at the
// output holds back the input. A sample's hit, if any, passes through the input
// register and then the result register before the output can take it. Each sample
// does a single read-modify-write of its pad's state registers between the input
// register and the result register, so back-to-back samples of the same pad see
// each other's updates. A pad opens a scan window on a sample above the threshold,
// reports its peak on the first sample at or after the scan length, then ignores
// samples until the mask length has passed. Pads at or above PAD_TOTAL are dropped.
// Thresholds and lengths must be written through the APB port while no sample is
// in flight; the user is bound by this, as the block does not enforce it.
module multi_pad_peak_trigger_unit import mppt_pkg::*; #(
    parameter int PAD_TOTAL   = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mppt_sample_if.sink           i_sample,
    mppt_hit_if.source            o_hit,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PAD_MAX   = 1 << PAD_W;
    localparam int PAD_DEPTH = (PAD_TOTAL < PAD_MAX) ? PAD_TOTAL : PAD_MAX;
    localparam int PAD_IW    = (PAD_DEPTH > 1) ? $clog2(PAD_DEPTH) : 1;
    localparam logic [PAD_W:0] PAD_LIMIT = (PAD_W+1)'(PAD_DEPTH);
    localparam logic [SAMPLE_W-1:0] SMP_MASK =
        (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [PAD_W-1:0]    r_in_pad;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic [TIME_W-1:0]   r_in_now;
    logic                r_out_valid;
    logic [PAD_W-1:0]    r_out_pad;
    logic [SAMPLE_W-1:0] r_out_peak;
    t_pad_state          r_pad_state [PAD_DEPTH];

    t_pad_state          cur_state;
    t_pad_state          n_pad_state;
    logic                emit;
    logic                in_range;
    logic                advance;
    logic [PAD_IW-1:0]   pad_idx;
    t_reg_idx            reg_idx;
    logic                cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RESET;
            r_cfg.scan_len  <= SCAN_LEN_RESET;
            r_cfg.mask_len  <= MASK_LEN_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_THRESHOLD: r_cfg.threshold <= pwdata[SAMPLE_W-1:0];
                REG_SCAN_LEN:  r_cfg.scan_len  <= pwdata[SCAN_W-1:0];
                REG_MASK_LEN:  r_cfg.mask_len  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = {{(CFG_DATA_W-SAMPLE_W){1'b0}}, r_cfg.threshold};
            REG_SCAN_LEN:  prdata = {{(CFG_DATA_W-SCAN_W){1'b0}}, r_cfg.scan_len};
            REG_MASK_LEN:  prdata = {{(CFG_DATA_W-MASK_W){1'b0}}, r_cfg.mask_len};
            default:       prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // The stage moves on whenever the result register is empty or drains.
    assign advance        = !r_out_valid || o_hit.ready;
    assign i_sample.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_pad    <= i_sample.pad_index;
            r_in_sample <= i_sample.sample & SMP_MASK;
            r_in_now    <= i_sample.now_ms;
        end
    end

    // ---------------- per-pad state ----------------
    assign in_range = {1'b0, r_in_pad} < PAD_LIMIT;
    assign pad_idx  = PAD_IW'(r_in_pad);

    always_comb begin
        cur_state = '{phase: PH_IDLE, peak: '0, start: '0};
        if (in_range) begin
            cur_state = r_pad_state[pad_idx];
        end
    end

    mppt_pad_engine u_engine (
        .i_cfg    (r_cfg),
        .i_state  (cur_state),
        .i_sample (r_in_sample),
        .i_now    (r_in_now),
        .o_state  (n_pad_state),
        .o_emit   (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAD_DEPTH; k++) begin
                r_pad_state[k] <= '{phase: PH_IDLE, peak: '0, start: '0};
            end
        end else if (r_in_valid && advance && in_range) begin
            r_pad_state[pad_idx] <= n_pad_state;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && in_range && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && in_range && emit) begin
            r_out_pad  <= r_in_pad;
            r_out_peak <= n_pad_state.peak;
        end
    end

    assign o_hit.valid      = r_out_valid;
    assign o_hit.hit_pad    = r_out_pad;
    assign o_hit.peak_value = r_out_peak;

endmodule

// ===== rtl/mppt_pad_engine.sv =====
// Next-state logic of one pad: scan window, peak tracking and mask timer.
// Purely combinational; depends on mppt_pkg.
module mppt_pad_engine import mppt_pkg::*; (
    input  t_cfg                i_cfg,
    input  t_pad_state          i_state,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [TIME_W-1:0]   i_now,
    output t_pad_state          o_state,
    output logic                o_emit
);

    logic [TIME_W-1:0]   elapsed;
    logic [SAMPLE_W-1:0] max_peak;

    // Time difference wraps modulo 2^32 by construction.
    assign elapsed  = i_now - i_state.start;
    assign max_peak = (i_sample > i_state.peak) ? i_sample : i_state.peak;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        case (i_state.phase)
            PH_COLLECT: begin
                o_state.peak = max_peak;
                if (elapsed >= {{(TIME_W-SCAN_W){1'b0}}, i_cfg.scan_len}) begin
                    o_emit        = 1'b1;
                    o_state.start = i_now;
                    o_state.phase = PH_MASK;
                end
            end
            PH_MASK: begin
                if (elapsed >= {{(TIME_W-MASK_W){1'b0}}, i_cfg.mask_len}) begin
                    o_state.peak  = '0;
                    o_state.phase = PH_IDLE;
                end
            end
            default: begin
                // The onset sample only opens the window; it never ends it.
                if (i_sample > i_cfg.threshold) begin
                    o_state.peak  = i_sample;
                    o_state.start = i_now;
                    o_state.phase = PH_COLLECT;
                end
            end
        endcase
    end

endmodule

// ===== rtl/mppt_checker.sv =====
// Port-level checker for the multi-pad peak trigger unit, attached by bind.
// Depends on mppt_pkg and on the top level's port names.
module mppt_checker import mppt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [PAD_W-1:0]      i_hit_pad,
    input logic [SAMPLE_W-1:0]   i_peak_value,
    input logic                  i_psel,
    input logic                  i_penable,
    input logic                  i_pwrite,
    input logic [CFG_ADDR_W-1:0] i_paddr,
    input logic [CFG_DATA_W-1:0] i_pwdata,
    input logic [CFG_DATA_W-1:0] i_prdata,
    input logic                  i_pready
);

    localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

    // A stalled hit keeps its payload until it is taken.
    a_hit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hit_pad) && $stable(i_peak_value))
        else $error("hit payload changed while stalled");

    // A fresh hit after an empty result slot comes from a past sample transfer.
    a_hit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("hit appeared without a sample transfer");

    // The threshold register reads back what was written, masked to 12 bits.
    a_threshold_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_pready && (i_paddr == THRESHOLD_ADDR) |=>
            ((i_paddr == THRESHOLD_ADDR) |->
                (i_prdata == {{(CFG_DATA_W-SAMPLE_W){1'b0}}, $past(i_pwdata[SAMPLE_W-1:0])})))
        else $error("threshold readback mismatch");

    // The register port never inserts wait states.
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel |-> i_pready)
        else $error("pready dropped");

endmodule

bind multi_pad_peak_trigger_unit mppt_checker u_mppt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_hit.valid),
    .i_out_ready  (o_hit.ready),
    .i_hit_pad    (o_hit.hit_pad),
    .i_peak_value (o_hit.peak_value),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata),
    .i_pready     (pready)
);
